FILE: hdl/oft_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the open-file slot table.
// Depends on nothing; imported by open_file_slot_table.

package oft_pkg;

    // Table geometry.
    localparam int ENTRIES = 16;
    localparam int SECTORS = 1024;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = $clog2(ENTRIES + 1);

    // Fixed field widths of the stream payload.
    localparam int ACT_W   = 2;
    localparam int SEC_W   = 10;
    localparam int MODE_W  = 8;
    localparam int SLOT_W  = 4;
    localparam int STS_W   = 2;
    localparam int COUNT_W = 5;
    localparam int IN_W    = 24;
    localparam int OUT_W   = 32;

    // Width of one stored entry: sector in the high bits, mode in the low bits.
    localparam int ENT_W   = SEC_W + MODE_W;

    // Request kinds.
    typedef enum logic [ACT_W-1:0] {
        ACT_OPEN  = 2'd0,
        ACT_CLOSE = 2'd1,
        ACT_GET   = 2'd2
    } t_action;

    // Result status codes.
    typedef enum logic [STS_W-1:0] {
        STS_ADDED = 2'd0,
        STS_OK    = 2'd1,
        STS_FULL  = 2'd2,
        STS_BAD   = 2'd3
    } t_status;

    // Control sequencer states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_GET,
        S_RESP
    } t_state;

endpackage

FILE: hdl/oft_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM with one write port and a registered read port.
// Depends on nothing.

module oft_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

FILE: hdl/open_file_slot_table.sv
`timescale 1ns / 1ps
// Open-file slot table: valid bits in flip-flops, sector and mode in a RAM.
// Depends on oft_pkg and oft_ram.

// Each request is open (by sector), close (by slot) or get (by slot) and gives one
// result. The block works on one request at a time. Close, unknown requests, an open
// of an out-of-range sector and a get of an empty slot go straight to the result
// state, a get of an open slot first reads the slot from the RAM, and open walks the
// sector RAM one entry per cycle through its single read port, looking for a matching
// valid slot and remembering the lowest free one, and stops early on a match.
// The result is held in an output register, so the next request can be taken while it
// waits; a result that finds that register still full waits until the receiver takes
// the older one. Reset clears all valid marks and the used count at once; there is no
// clearing pass over the RAM.

module open_file_slot_table (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Request channel.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // sector_number[9:0], access_mode[17:10], slot_index[21:18]
    input  logic [1:0]  s_tuser,   // action[1:0]
    // Result channel.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // slot[3:0], entry_sector[13:4], entry_mode[21:14],
                                   // open_count[26:22]
    output logic [1:0]  m_tuser    // status[1:0]
);

    import oft_pkg::*;

    // Sequencer and table state.
    t_state               r_state, n_state;
    logic [ENTRIES-1:0]   r_valid, n_valid;
    logic [CNT_W-1:0]     r_count, n_count;

    // Captured request.
    logic [SEC_W-1:0]     r_sec, n_sec;
    logic [MODE_W-1:0]    r_mode, n_mode;
    logic [SLOT_W-1:0]    r_slot_in, n_slot_in;

    // Scan pipeline.
    logic [IDX_W-1:0]     r_addr, n_addr;
    logic                 r_cmp_on, n_cmp_on;
    logic [IDX_W-1:0]     r_cmp_idx, n_cmp_idx;
    logic                 r_free_found, n_free_found;
    logic [IDX_W-1:0]     r_free_idx, n_free_idx;

    // Pending result.
    t_status              r_res_sts, n_res_sts;
    logic [SLOT_W-1:0]    r_res_slot, n_res_slot;
    logic [SEC_W-1:0]     r_res_sec, n_res_sec;
    logic [MODE_W-1:0]    r_res_mode, n_res_mode;

    // Output register.
    logic                 r_out_valid, n_out_valid;
    logic [1:0]           r_out_user, n_out_user;
    logic [31:0]          r_out_data, n_out_data;

    // Input field views.
    logic [SEC_W-1:0]     in_sec;
    logic [MODE_W-1:0]    in_mode;
    logic [SLOT_W-1:0]    in_slot;
    t_action              in_act;
    logic                 in_accept;
    logic                 in_bad_idx;
    logic [IDX_W-1:0]     in_addr;

    // RAM ports.
    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    logic [ENT_W-1:0]     ram_wdata;
    logic [IDX_W-1:0]     ram_raddr;
    logic [ENT_W-1:0]     ram_rdata;
    logic [SEC_W-1:0]     ram_sec;
    logic [MODE_W-1:0]    ram_mode;

    // Scan decisions.
    logic                 cmp_valid;
    logic                 cmp_hit;
    logic                 cmp_last;
    logic [IDX_W-1:0]     alloc_idx;
    logic                 alloc_ok;
    logic                 alloc_go;
    logic                 out_free;

    assign in_sec     = s_tdata[SEC_W-1:0];
    assign in_mode    = s_tdata[SEC_W+MODE_W-1:SEC_W];
    assign in_slot    = s_tdata[SEC_W+MODE_W+SLOT_W-1:SEC_W+MODE_W];
    assign in_act     = t_action'(s_tuser);
    assign in_accept  = s_tvalid && s_tready;
    assign in_bad_idx = (32'(in_slot) >= ENTRIES);
    assign in_addr    = IDX_W'(in_slot);

    assign ram_sec    = ram_rdata[ENT_W-1:MODE_W];
    assign ram_mode   = ram_rdata[MODE_W-1:0];

    // Compare stage of the open scan: the RAM word belongs to r_cmp_idx.
    assign cmp_valid  = r_valid[r_cmp_idx];
    assign cmp_hit    = r_cmp_on && cmp_valid && (ram_sec == r_sec);
    assign cmp_last   = r_cmp_on && (r_cmp_idx == IDX_W'(ENTRIES - 1));
    assign alloc_idx  = r_free_found ? r_free_idx : r_cmp_idx;
    assign alloc_ok   = (r_free_found || !cmp_valid) && (32'(r_count) < ENTRIES);
    assign alloc_go   = (r_state == S_SCAN) && !cmp_hit && cmp_last && alloc_ok;
    assign out_free   = !r_out_valid || m_tready;

    // Sector and mode storage.
    oft_ram #(
        .WIDTH (ENT_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Outputs of the sequencer: handshake and RAM control.
    always_comb begin
        s_tready  = (r_state == S_IDLE);
        ram_raddr = (r_state == S_IDLE) ? in_addr : r_addr;
        ram_we    = alloc_go;
        ram_waddr = alloc_idx;
        ram_wdata = {r_sec, r_mode};
        m_tvalid  = r_out_valid;
        m_tdata   = r_out_data;
        m_tuser   = r_out_user;
    end

    // Next state of the sequencer, the table and the result path.
    always_comb begin
        n_state      = r_state;
        n_valid      = r_valid;
        n_count      = r_count;
        n_sec        = r_sec;
        n_mode       = r_mode;
        n_slot_in    = r_slot_in;
        n_addr       = r_addr;
        n_cmp_on     = r_cmp_on;
        n_cmp_idx    = r_cmp_idx;
        n_free_found = r_free_found;
        n_free_idx   = r_free_idx;
        n_res_sts    = r_res_sts;
        n_res_slot   = r_res_slot;
        n_res_sec    = r_res_sec;
        n_res_mode   = r_res_mode;
        n_out_valid  = r_out_valid && !m_tready;
        n_out_user   = r_out_user;
        n_out_data   = r_out_data;

        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_sec      = in_sec;
                    n_mode     = in_mode;
                    n_slot_in  = in_slot;
                    n_res_sec  = '0;
                    n_res_mode = '0;
                    n_res_slot = in_slot;
                    n_res_sts  = STS_BAD;
                    n_state    = S_RESP;
                    unique case (in_act)
                        ACT_OPEN: begin
                            n_res_slot = '0;
                            if (32'(in_sec) < SECTORS) begin
                                n_addr       = '0;
                                n_cmp_on     = 1'b0;
                                n_free_found = 1'b0;
                                n_state      = S_SCAN;
                            end
                        end
                        ACT_CLOSE: begin
                            if (!in_bad_idx && r_valid[in_addr]) begin
                                n_valid[in_addr] = 1'b0;
                                if (r_count != '0) begin
                                    n_count = r_count - CNT_W'(1);
                                end
                                n_res_sts = STS_OK;
                            end
                        end
                        ACT_GET: begin
                            // The RAM read of this slot is issued in this cycle.
                            if (!in_bad_idx && r_valid[in_addr]) begin
                                n_state = S_GET;
                            end
                        end
                        default: begin
                            n_res_sts = STS_BAD;
                        end
                    endcase
                end
            end

            S_SCAN: begin
                // Issue the next read and move the compare stage along.
                n_addr    = r_addr + IDX_W'(1);
                n_cmp_on  = 1'b1;
                n_cmp_idx = r_addr;
                if (r_cmp_on && !cmp_valid && !r_free_found) begin
                    n_free_found = 1'b1;
                    n_free_idx   = r_cmp_idx;
                end
                if (cmp_hit) begin
                    n_res_sts  = STS_OK;
                    n_res_slot = SLOT_W'(r_cmp_idx);
                    n_state    = S_RESP;
                end else if (cmp_last) begin
                    if (alloc_ok) begin
                        n_valid[alloc_idx] = 1'b1;
                        n_count            = r_count + CNT_W'(1);
                        n_res_sts          = STS_ADDED;
                        n_res_slot         = SLOT_W'(alloc_idx);
                    end else begin
                        n_res_sts  = STS_FULL;
                        n_res_slot = '0;
                    end
                    n_state = S_RESP;
                end
            end

            S_GET: begin
                n_res_sts  = STS_OK;
                n_res_slot = r_slot_in;
                n_res_sec  = ram_sec;
                n_res_mode = ram_mode;
                n_state    = S_RESP;
            end

            S_RESP: begin
                // Hand the result to the output register once it is free.
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_user  = r_res_sts;
                    n_out_data  = {5'd0, COUNT_W'(r_count), r_res_mode, r_res_sec,
                                   r_res_slot};
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_count     <= '0;
            r_cmp_on    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_valid     <= n_valid;
            r_count     <= n_count;
            r_cmp_on    <= n_cmp_on;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_sec        <= n_sec;
        r_mode       <= n_mode;
        r_slot_in    <= n_slot_in;
        r_addr       <= n_addr;
        r_cmp_idx    <= n_cmp_idx;
        r_free_found <= n_free_found;
        r_free_idx   <= n_free_idx;
        r_res_sts    <= n_res_sts;
        r_res_slot   <= n_res_slot;
        r_res_sec    <= n_res_sec;
        r_res_mode   <= n_res_mode;
        r_out_user   <= n_out_user;
        r_out_data   <= n_out_data;
    end

endmodule
